>>> src/sstf_pkg.sv
package sstf_pkg;

   localparam int TRACK_W = 16;
   localparam int SEEK_W  = 22;
   localparam int DELAY_W = 6;
   localparam int DSUM_W  = 11;
   localparam int DCNT_W  = 6;

   typedef struct packed {
      logic [TRACK_W-1:0] track;
      logic               last_request;
   } req_type;

   typedef struct packed {
      logic [TRACK_W-1:0] served_track;
      logic [TRACK_W-1:0] step_distance;
      logic [SEEK_W-1:0]  seek_total;
      logic [DELAY_W-1:0] longest_delay;
      logic [DSUM_W-1:0]  delay_sum;
      logic [DCNT_W-1:0]  delayed_count;
      logic               run_end;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_HEAD,
      ST_SEL,
      ST_SERVE,
      ST_ORIG,
      ST_EMIT
   } sstf_state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // write accepted item into the store
      logic sel_start;  // start nearest-request scan
      logic serve;      // commit best pick, start first-index scan
      logic emit_head;  // load head item into output register
      logic emit_step;  // load served item into output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic sel_done;
      logic orig_done;
      logic single;
      logic last_step;
      logic out_free;
   } stat_type;

endpackage

>>> src/sstf_ctrl.sv
module sstf_ctrl import sstf_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  req_type  req,
   input  stat_type stat,
   output logic     req_stall,
   output cmd_type  cmd
);

   sstf_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid && req.last_request) state_in = ST_HEAD;
         end
         ST_HEAD: begin
            if (stat.out_free) state_in = stat.single ? ST_LOAD : ST_SEL;
         end
         ST_SEL: begin
            if (stat.sel_done) state_in = ST_SERVE;
         end
         ST_SERVE: begin
            state_in = ST_ORIG;
         end
         ST_ORIG: begin
            if (stat.orig_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.out_free) state_in = stat.last_step ? ST_LOAD : ST_SEL;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_LOAD: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_HEAD: begin
            cmd.emit_head = stat.out_free;
            cmd.sel_start = stat.out_free && !stat.single;
         end
         ST_SEL: begin
         end
         ST_SERVE: begin
            cmd.serve = 1'b1;
         end
         ST_ORIG: begin
         end
         ST_EMIT: begin
            cmd.emit_step = stat.out_free;
            cmd.sel_start = stat.out_free && !stat.last_step;
         end
         default: begin
         end
      endcase
   end

endmodule

>>> src/sstf_dpath.sv
module sstf_dpath import sstf_pkg::*; #(
   parameter int MAX_ENTRIES = 32
) (
   input  logic     clock,
   input  logic     reset,
   input  req_type  req,
   input  cmd_type  cmd,
   input  logic     rsp_stall,
   output stat_type stat,
   output logic     rsp_valid,
   output rsp_type  rsp
);

   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int IW = $clog2(MAX_ENTRIES);

   logic [TRACK_W-1:0] mem_ff [MAX_ENTRIES];
   logic [TRACK_W-1:0] rd_data_ff;

   logic [CW-1:0]          count_ff, count_in;
   logic [TRACK_W-1:0]     head_ff, head_in;
   logic [MAX_ENTRIES-1:0] served_ff, served_in;
   logic [IW-1:0]          step_ff, step_in;
   logic [SEEK_W-1:0]      seek_ff, seek_in;
   logic [DELAY_W-1:0]     longest_ff, longest_in;
   logic [DSUM_W-1:0]      dsum_ff, dsum_in;
   logic [DCNT_W-1:0]      dcnt_ff, dcnt_in;

   logic [IW-1:0]          addr_ff, addr_in;
   logic                   scan_ff, scan_in;
   logic                   orig_mode_ff, orig_mode_in;
   logic                   pend_ff, pend_in;
   logic [IW-1:0]          pend_idx_ff, pend_idx_in;

   logic                   found_ff, found_in;
   logic [IW-1:0]          best_idx_ff, best_idx_in;
   logic [TRACK_W-1:0]     best_d_ff, best_d_in;
   logic [TRACK_W-1:0]     best_trk_ff, best_trk_in;

   rsp_type                rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic [CW-1:0]          last_idx;
   logic                   store_open;
   logic [TRACK_W-1:0]     gap;
   logic                   sel_hit;
   logic                   match;
   logic [IW-1:0]          dly;

   // store: one write port on load, one registered read port for the scans
   always_ff @(posedge clock) begin
      if (cmd.load && store_open) begin
         mem_ff[count_ff[IW-1:0]] <= req.track;
      end
      if (scan_ff) begin
         rd_data_ff <= mem_ff[addr_ff];
      end
   end

   always_comb begin
      last_idx   = count_ff - CW'(1);
      store_open = count_ff < CW'(MAX_ENTRIES);
      gap        = (rd_data_ff >= head_ff) ? rd_data_ff - head_ff : head_ff - rd_data_ff;
      sel_hit    = pend_ff && !orig_mode_ff && !served_ff[pend_idx_ff] &&
                   (!found_ff || gap < best_d_ff);
      match      = pend_ff && orig_mode_ff && (rd_data_ff == head_ff);
      dly        = step_ff - pend_idx_ff;

      stat.sel_done  = pend_ff && !orig_mode_ff && (CW'(pend_idx_ff) == last_idx);
      stat.orig_done = match;
      stat.single    = count_ff == CW'(1);
      stat.last_step = CW'(step_ff) == last_idx;
      stat.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      count_in     = count_ff;
      head_in      = head_ff;
      served_in    = served_ff;
      step_in      = step_ff;
      seek_in      = seek_ff;
      longest_in   = longest_ff;
      dsum_in      = dsum_ff;
      dcnt_in      = dcnt_ff;
      addr_in      = addr_ff;
      scan_in      = scan_ff;
      orig_mode_in = orig_mode_ff;
      pend_in      = scan_ff;
      pend_idx_in  = addr_ff;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_d_in    = best_d_ff;
      best_trk_in  = best_trk_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (cmd.load && store_open) begin
         count_in = count_ff + CW'(1);
         if (count_ff == '0) head_in = req.track;
      end

      // read issue: stop at the last held entry
      if (scan_ff) begin
         if (CW'(addr_ff) == last_idx) scan_in = 1'b0;
         else addr_in = addr_ff + IW'(1);
      end

      if (sel_hit) begin
         found_in    = 1'b1;
         best_idx_in = pend_idx_ff;
         best_d_in   = gap;
         best_trk_in = rd_data_ff;
      end

      // first loaded index holding the new head; drop reads still in flight
      if (match) begin
         scan_in = 1'b0;
         pend_in = 1'b0;
         if (step_ff > pend_idx_ff) begin
            dsum_in = dsum_ff + DSUM_W'(dly);
            dcnt_in = dcnt_ff + DCNT_W'(1);
            if (DELAY_W'(dly) > longest_ff) longest_in = DELAY_W'(dly);
         end
      end

      if (cmd.sel_start) begin
         scan_in      = 1'b1;
         addr_in      = IW'(1);
         orig_mode_in = 1'b0;
         found_in     = 1'b0;
      end

      if (cmd.serve) begin
         served_in[best_idx_ff] = 1'b1;
         seek_in      = seek_ff + SEEK_W'(best_d_ff);
         head_in      = best_trk_ff;
         scan_in      = 1'b1;
         addr_in      = '0;
         orig_mode_in = 1'b1;
      end

      if (cmd.emit_head) begin
         rsp_in.served_track  = head_ff;
         rsp_in.step_distance = '0;
         rsp_in.seek_total    = '0;
         rsp_in.longest_delay = '0;
         rsp_in.delay_sum     = '0;
         rsp_in.delayed_count = '0;
         rsp_in.run_end       = stat.single;
         rsp_valid_in         = 1'b1;
         step_in              = IW'(1);
      end

      if (cmd.emit_step) begin
         rsp_in.served_track  = head_ff;
         rsp_in.step_distance = best_d_ff;
         rsp_in.seek_total    = seek_ff;
         rsp_in.longest_delay = longest_ff;
         rsp_in.delay_sum     = dsum_ff;
         rsp_in.delayed_count = dcnt_ff;
         rsp_in.run_end       = stat.last_step;
         rsp_valid_in         = 1'b1;
         step_in              = step_ff + IW'(1);
      end

      // run finished: next item opens a new run
      if ((cmd.emit_head && stat.single) || (cmd.emit_step && stat.last_step)) begin
         count_in   = '0;
         served_in  = '0;
         seek_in    = '0;
         longest_in = '0;
         dsum_in    = '0;
         dcnt_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         served_ff    <= '0;
         seek_ff      <= '0;
         longest_ff   <= '0;
         dsum_ff      <= '0;
         dcnt_ff      <= '0;
         scan_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         served_ff    <= served_in;
         seek_ff      <= seek_in;
         longest_ff   <= longest_in;
         dsum_ff      <= dsum_in;
         dcnt_ff      <= dcnt_in;
         scan_ff      <= scan_in;
         pend_ff      <= pend_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff      <= head_in;
      step_ff      <= step_in;
      addr_ff      <= addr_in;
      orig_mode_ff <= orig_mode_in;
      pend_idx_ff  <= pend_idx_in;
      best_idx_ff  <= best_idx_in;
      best_d_ff    <= best_d_in;
      best_trk_ff  <= best_trk_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

>>> src/sstf_disk_scheduler.sv
// Loading: one item per cycle until the last item of a run closes the input.
// The head result then enters the output register once the output is free;
// each served track of an n-entry run then needs two passes of the store's
// single read port: one pass for the nearest pick, one for the first index.
// Reset (synchronous) clears the controller, run counters and statistics;
// the track store holds no reset value and is only read where written.
module sstf_disk_scheduler import sstf_pkg::*; #(
   parameter int MAX_ENTRIES = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp
);

   cmd_type  cmd;
   stat_type stat;

   sstf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req       (req),
      .stat      (stat),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   sstf_dpath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .cmd       (cmd),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

endmodule

>>> src/sstf_checker.sv
module sstf_checker import sstf_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
      else $error("stalled result changed");

   // the last item of a run starts scheduling, so the input closes
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req.last_request |=> req_stall)
      else $error("input open after last item");

   a_seek_cover: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp.seek_total >= SEEK_W'(rsp.step_distance))
      else $error("seek total below step distance");

   a_delay_stats: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.delayed_count == '0 |->
         rsp.delay_sum == '0 && rsp.longest_delay == '0)
      else $error("delay statistics inconsistent");

endmodule

bind sstf_disk_scheduler sstf_checker u_sstf_checker (.*);

>>> tb/sstf_checker.sv
`timescale 1ns / 100ps

module sstf_scoreboard import sstf_pkg::*; #(
   parameter int MAX_ENTRIES = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp,
   output int      fail_count,
   output int      waiting,
   output int      runs_done,
   output int      served_seen
);

   logic [TRACK_W-1:0] track_store [MAX_ENTRIES];
   int      loaded = 0;
   rsp_type service_order [$];
   rsp_type want;
   int      errors = 0;
   int      runs = 0;
   int      served = 0;

   task automatic report_mismatch(input string what, input longint got, input longint ref_val);
      if (errors < 30)
         $display("%0t ns: %s mismatch, got %0d, want %0d", $time, what, got, ref_val);
      errors++;
   endtask

   // Nearest-first service order of the loaded run, with running stats.
   task automatic plan_service();
      bit                 done_mark [MAX_ENTRIES];
      logic [TRACK_W-1:0] head;
      int                 seek, longest, dsum, dcnt, lag;
      int                 k, i, best, best_d, d, first_idx;
      rsp_type            r;
      head = track_store[0];
      seek = 0;
      longest = 0;
      dsum = 0;
      dcnt = 0;
      r = '0;
      r.served_track = head;
      r.run_end = (loaded == 1);
      service_order.push_back(r);
      for (k = 1; k < loaded; k++) begin
         best = -1;
         best_d = 0;
         for (i = 1; i < loaded; i++) begin
            d = (head > track_store[i]) ? int'(head) - int'(track_store[i])
                                        : int'(track_store[i]) - int'(head);
            // strict less-than keeps the earliest entry on a tie
            if (!done_mark[i] && (best < 0 || d < best_d)) begin
               best = i;
               best_d = d;
            end
         end
         done_mark[best] = 1'b1;
         seek += best_d;
         head = track_store[best];
         first_idx = 0;
         for (i = loaded - 1; i >= 0; i--)
            if (track_store[i] == head) first_idx = i;
         lag = (k > first_idx) ? k - first_idx : 0;
         if (lag > 0) begin
            dsum += lag;
            dcnt++;
         end
         if (lag > longest) longest = lag;
         r.served_track  = head;
         r.step_distance = TRACK_W'(best_d);
         r.seek_total    = SEEK_W'(seek);
         r.longest_delay = DELAY_W'(longest);
         r.delay_sum     = DSUM_W'(dsum);
         r.delayed_count = DCNT_W'(dcnt);
         r.run_end       = (k == loaded - 1);
         service_order.push_back(r);
      end
      loaded = 0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         loaded = 0;
         service_order.delete();
      end else begin
         if (req_valid && !req_stall) begin
            // a full store drops the item, but its last flag still counts
            if (loaded < MAX_ENTRIES) begin
               track_store[loaded] = req.track;
               loaded++;
            end
            if (req.last_request) begin
               plan_service();
               runs++;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (service_order.size() == 0) begin
               report_mismatch("unexpected item, served_track",
                               longint'(rsp.served_track), longint'(-1));
            end else begin
               want = service_order.pop_front();
               if (rsp.served_track != want.served_track)
                  report_mismatch("served_track", longint'(rsp.served_track),
                                  longint'(want.served_track));
               if (rsp.step_distance != want.step_distance)
                  report_mismatch("step_distance", longint'(rsp.step_distance),
                                  longint'(want.step_distance));
               if (rsp.seek_total != want.seek_total)
                  report_mismatch("seek_total", longint'(rsp.seek_total),
                                  longint'(want.seek_total));
               if (rsp.longest_delay != want.longest_delay)
                  report_mismatch("longest_delay", longint'(rsp.longest_delay),
                                  longint'(want.longest_delay));
               if (rsp.delay_sum != want.delay_sum)
                  report_mismatch("delay_sum", longint'(rsp.delay_sum),
                                  longint'(want.delay_sum));
               if (rsp.delayed_count != want.delayed_count)
                  report_mismatch("delayed_count", longint'(rsp.delayed_count),
                                  longint'(want.delayed_count));
               if (rsp.run_end != want.run_end)
                  report_mismatch("run_end", longint'(rsp.run_end),
                                  longint'(want.run_end));
               served++;
            end
         end
      end
      fail_count  <= errors;
      waiting     <= service_order.size();
      runs_done   <= runs;
      served_seen <= served;
   end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top import sstf_pkg::*; ();

   localparam int MAX_ENTRIES = 32;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int HOLD_CYCLES = 400;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   req_type req = '0;
   logic    rsp_stall = 1'b0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp;

   int fail_count, waiting, runs_done, served_seen;
   int tx_idle = 0;
   int rx_idle = 0;
   int hold_asked = 0;
   int hold_done = 0;
   int hold_left = 0;
   int cycles = 0;
   int items_sent = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   sstf_disk_scheduler #(.MAX_ENTRIES(MAX_ENTRIES)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   sstf_scoreboard #(.MAX_ENTRIES(MAX_ENTRIES)) u_scoreboard (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req         (req),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp         (rsp),
      .fail_count  (fail_count),
      .waiting     (waiting),
      .runs_done   (runs_done),
      .served_seen (served_seen)
   );

   // result side: long hold-off on request, random stalls otherwise
   always @(posedge clock) begin
      if (hold_asked != hold_done) begin
         hold_done <= hold_asked;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_idle);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("run stopped at cycle limit %0d, %0d results outstanding", cycles, waiting);
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic send_item(input logic [TRACK_W-1:0] trk, input logic lst);
      while ($urandom_range(99) < tx_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req <= '{track: trk, last_request: lst};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // clustered and repeated tracks make ties and duplicate entries likely
   function automatic logic [TRACK_W-1:0] pick_track(input int style,
                                                     input logic [TRACK_W-1:0] base);
      case (style)
         0:       return TRACK_W'($urandom_range(0, 65535));
         1:       return base + TRACK_W'($urandom_range(0, 15));
         2:       return base + TRACK_W'(3 * $urandom_range(0, 3));
         default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      endcase
   endfunction

   task automatic send_run(input int len);
      int                 style, i, pick;
      logic [TRACK_W-1:0] base;
      pick = $urandom_range(99);
      style = (pick < 40) ? 0 : (pick < 70) ? 1 : (pick < 92) ? 2 : 3;
      base = TRACK_W'($urandom_range(0, 65535));
      for (i = 0; i < len; i++)
         send_item(pick_track(style, base), i == len - 1);
   endtask

   task automatic random_run();
      int pick, len;
      pick = $urandom_range(99);
      if (pick < 15)      len = 1;
      else if (pick < 75) len = $urandom_range(2, 8);
      else if (pick < 94) len = $urandom_range(9, MAX_ENTRIES);
      else                len = $urandom_range(MAX_ENTRIES + 1, MAX_ENTRIES + 8);
      send_run(len);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (waiting != 0) @(posedge clock);
   endtask

   task automatic run_phase(input int tx, input int rx, input int quota);
      int start;
      tx_idle = tx;
      rx_idle <= rx;
      start = items_sent;
      while (items_sent - start < quota) random_run();
      wait_drained();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // single-entry runs at both extremes
      send_item(16'hFFFF, 1'b1);
      send_item(16'h0000, 1'b1);
      // tie at equal distance, duplicate request
      send_item(16'd1000, 1'b0);
      send_item(16'd990, 1'b0);
      send_item(16'd1010, 1'b0);
      send_item(16'd1010, 1'b0);
      send_item(16'd995, 1'b1);
      // requests equal to the head, full-range seeks
      send_item(16'h0000, 1'b0);
      send_item(16'hFFFF, 1'b0);
      send_item(16'h0000, 1'b0);
      send_item(16'h8000, 1'b0);
      send_item(16'hFFFF, 1'b1);
      // alternating bit patterns
      send_item(16'h5555, 1'b0);
      send_item(16'hAAAA, 1'b0);
      send_item(16'h0F0F, 1'b0);
      send_item(16'hF0F0, 1'b1);
      wait_drained();

      run_phase(28, 82, 135);
      run_phase(82, 28, 135);

      // result side holds off while an overfull run and more runs pile in
      tx_idle = 0;
      rx_idle <= 0;
      hold_asked <= hold_asked + 1;
      send_run(MAX_ENTRIES + 4);
      send_run(5);
      send_run(1);
      wait_drained();

      run_phase(0, 0, 135);

      repeat (200) @(posedge clock);
      $display("%0d items loaded in %0d runs, %0d served tracks checked",
               items_sent, runs_done, served_seen);
      $display("ties, duplicates, single-entry and overfull runs under mixed stalls");
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
